[rtl/cbp_pkg.sv]
package cbp_pkg;

  localparam int unsigned ModulusQ   = 3329;
  localparam int unsigned MaxWidth   = 12;
  localparam int unsigned RecipMul   = 20158;
  localparam int unsigned RecipShift = 26;
  localparam int unsigned QueueDepth = 4;

  typedef logic [3:0]  width_t;
  typedef logic [11:0] coeff12_t;

  typedef struct packed {
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
    logic       two;
    logic       last;
  } entry_t;

endpackage

[rtl/cbp_front.sv]
module cbp_front #(
  parameter int CoeffsPerPoly = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [15:0]     coeff_i,
  input  cbp_pkg::width_t width_i,
  input  logic            full_i,
  output logic            push_o,
  output cbp_pkg::entry_t entry_o
);

  localparam int IdxW = $clog2(CoeffsPerPoly);

  logic                  s1_valid_q, s1_valid_d;
  logic [15:0]           s1_coeff_q, s1_coeff_d;
  logic [30:0]           s1_prod_q, s1_prod_d;
  logic                  s2_valid_q, s2_valid_d;
  cbp_pkg::coeff12_t     s2_low_q, s2_low_d;
  cbp_pkg::coeff12_t     s2_rem_q, s2_rem_d;
  logic [6:0]            pend_q, pend_d;
  logic [2:0]            pcnt_q, pcnt_d;
  logic [IdxW-1:0]       idx_q, idx_d;

  logic                  s2_accept;
  logic                  adv;
  logic                  final_coeff;
  logic [4:0]            quot;
  logic [16:0]           diff;
  logic [16:0]           diff_fix;
  cbp_pkg::coeff12_t     mask;
  cbp_pkg::coeff12_t     a;
  logic [18:0]           acc;
  logic [4:0]            cnt;
  logic [1:0]            nfull;
  logic                  extra;
  logic [1:0]            nbytes;

  assign adv         = s2_valid_q && !full_i;
  assign s2_accept   = !s2_valid_q || adv;
  assign in_ready_o  = !s1_valid_q || s2_accept;
  assign final_coeff = (idx_q == IdxW'(CoeffsPerPoly - 1));

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_coeff_d = s1_coeff_q;
    s1_prod_d  = s1_prod_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
      s1_coeff_d = coeff_i;
      s1_prod_d  = 31'(coeff_i) * 31'(cbp_pkg::RecipMul);
    end
  end

  always_comb begin
    quot     = s1_prod_q[30:cbp_pkg::RecipShift];
    diff     = 17'(s1_coeff_q) - 17'(quot) * 17'(cbp_pkg::ModulusQ);
    diff_fix = (diff >= 17'(cbp_pkg::ModulusQ)) ? diff - 17'(cbp_pkg::ModulusQ) : diff;
    s2_valid_d = s2_valid_q;
    s2_low_d   = s2_low_q;
    s2_rem_d   = s2_rem_q;
    if (s2_accept) begin
      s2_valid_d = s1_valid_q;
      s2_low_d   = s1_coeff_q[11:0];
      s2_rem_d   = diff_fix[11:0];
    end
  end

  always_comb begin
    mask   = 12'((13'd1 << width_i) - 13'd1);
    a      = (width_i == 4'(cbp_pkg::MaxWidth)) ? s2_rem_q : (s2_low_q & mask);
    acc    = 19'(pend_q) | (19'(a) << pcnt_q);
    cnt    = 5'(pcnt_q) + 5'(width_i);
    nfull  = (cnt >= 5'd16) ? 2'd2 : ((cnt >= 5'd8) ? 2'd1 : 2'd0);
    extra  = final_coeff && (cnt[2:0] != 3'd0) && (nfull != 2'd2);
    nbytes = nfull + 2'(extra);

    entry_o.lo_byte = acc[7:0];
    entry_o.hi_byte = acc[15:8];
    entry_o.two     = (nbytes == 2'd2);
    entry_o.last    = final_coeff;
    push_o          = adv && (nbytes != 2'd0);

    pend_d = pend_q;
    pcnt_d = pcnt_q;
    idx_d  = idx_q;
    if (adv) begin
      if (final_coeff) begin
        pend_d = '0;
        pcnt_d = '0;
        idx_d  = '0;
      end else begin
        unique case (nfull)
          2'd0:    pend_d = acc[6:0];
          2'd1:    pend_d = acc[14:8];
          default: pend_d = {4'b0000, acc[18:16]};
        endcase
        pcnt_d = cnt[2:0];
        idx_d  = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      pend_q     <= '0;
      pcnt_q     <= '0;
      idx_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      pend_q     <= pend_d;
      pcnt_q     <= pcnt_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_coeff_q <= s1_coeff_d;
    s1_prod_q  <= s1_prod_d;
    s2_low_q   <= s2_low_d;
    s2_rem_q   <= s2_rem_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && final_coeff) |=> (idx_q == '0 && pcnt_q == '0 && pend_q == '0))
    else $error("packer state did not restart after the final coefficient");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && final_coeff) |-> push_o)
    else $error("final coefficient produced no byte transfer");

endmodule

[rtl/cbp_fifo.sv]
module cbp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cbp_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output cbp_pkg::entry_t head_o,
  output logic            empty_o
);

  localparam int Depth = cbp_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  cbp_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = push_i ? PtrW'(wptr_q + PtrW'(1)) : wptr_q;
    rptr_d  = pop_i ? PtrW'(rptr_q + PtrW'(1)) : rptr_q;
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds its depth");

endmodule

[rtl/cbp_back.sv]
module cbp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cbp_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       last_q, last_d;
  logic       sel_q, sel_d;
  logic       load;
  logic       final_byte;

  assign final_byte = sel_q || !head_i.two;
  assign load       = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o      = load && final_byte;

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    sel_d       = sel_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_q ? head_i.hi_byte : head_i.lo_byte;
      last_d      = head_i.last && final_byte;
      sel_d       = !final_byte;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (!empty_i && head_i.two))
    else $error("second byte selected without a two-byte entry at the head");

endmodule

[rtl/coeff_byte_packer_core.sv]
// An accepted coefficient passes the product and remainder registers, the queue and the
// byte output register before its first byte is valid on the output.
// Throughput: one coefficient per cycle while each yields at most one byte and the
// queue is not full and the output is not held back; above d = 8 the byte-wide output
// register sets the pace.
// Reset clears the valid flags, queue pointers and packer state and sets the width register to 12.
module coeff_byte_packer_core #(
  parameter int CoeffsPerPoly = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] coeff_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  cbp_pkg::width_t width_q, width_d;
  cbp_pkg::width_t eff_width;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  cbp_pkg::entry_t entry;
  cbp_pkg::entry_t head;

  always_comb begin
    width_d = cfg_we_i ? cfg_wdata_i : width_q;
    if (width_q == '0) begin
      eff_width = 4'd1;
    end else if (width_q > 4'(cbp_pkg::MaxWidth)) begin
      eff_width = 4'(cbp_pkg::MaxWidth);
    end else begin
      eff_width = width_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 4'(cbp_pkg::MaxWidth);
    end else begin
      width_q <= width_d;
    end
  end

  cbp_front #(
    .CoeffsPerPoly(CoeffsPerPoly)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .coeff_i   (coeff_i),
    .width_i   (eff_width),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (entry)
  );

  cbp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty)
  );

  cbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule
